// ----- sv/wpsd_pkg.sv -----
// wpsd_pkg: shared constants, payload types and helpers for the window
// position stability detector; used by wpsd_mac, the top level and the checker
// no dependencies
package wpsd_pkg;

   // window and field geometry
   localparam int WINDOW   = 30;
   localparam int AXIS_CNT = 3;
   localparam int SAMPLE_W = 16;
   localparam int LIMIT_W  = 24;
   localparam int FILL_W   = 7;
   localparam int S1_W     = 23;
   localparam int S2_W     = 37;

   // derived widths
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int N_W    = $clog2(WINDOW + 1);
   localparam int MUL_W  = 24;
   localparam int PROD_W = 2 * MUL_W;
   localparam int D_W    = S2_W + N_W;
   localparam int R_W    = LIMIT_W + 2 * N_W;
   localparam int ACC_W  = 2 * D_W + 3;
   localparam int DIFF_W = (D_W > PROD_W) ? D_W : PROD_W;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 24'd104858;

   typedef logic [1:0] axis_type;
   localparam axis_type AXIS_X    = 2'd0;
   localparam axis_type AXIS_Y    = 2'd1;
   localparam axis_type AXIS_Z    = 2'd2;
   localparam axis_type AXIS_LAST = AXIS_Z;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] tag_x;
      logic signed [SAMPLE_W-1:0] tag_y;
      logic signed [SAMPLE_W-1:0] tag_z;
   } wpsd_req_type;

   typedef struct packed {
      logic              stable;
      logic [FILL_W-1:0] fill_level;
   } wpsd_rsp_type;

   // accumulator operation, applied in the cycle after the multiply
   typedef enum logic [1:0] {
      ACC_NONE,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   // weight of a partial product in the accumulator
   typedef enum logic [1:0] {
      SHIFT_LOW,
      SHIFT_MID,
      SHIFT_HIGH
   } shift_type;

   typedef struct packed {
      logic             clear;
      logic [MUL_W-1:0] mul_a;
      logic [MUL_W-1:0] mul_b;
      acc_op_type       acc_op;
      shift_type        shift;
   } wpsd_mac_cmd_type;

   // pick one axis out of a sample
   function automatic logic signed [SAMPLE_W-1:0] sample_axis(wpsd_req_type s, axis_type a);
      logic signed [SAMPLE_W-1:0] v;
      unique case (a)
         AXIS_X:  v = s.tag_x;
         AXIS_Y:  v = s.tag_y;
         default: v = s.tag_z;
      endcase
      return v;
   endfunction

   // magnitude of a sample, most negative value maps to 2^15
   function automatic logic [SAMPLE_W-1:0] mag_sample(logic signed [SAMPLE_W-1:0] v);
      return v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
   endfunction

   // magnitude of a running sum
   function automatic logic [S1_W-1:0] mag_sum(logic signed [S1_W-1:0] v);
      return v[S1_W-1] ? S1_W'(-v) : S1_W'(v);
   endfunction

endpackage

// ----- sv/wpsd_ram.sv -----
// wpsd_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module wpsd_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 30
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic                                          rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/wpsd_mac.sv -----
// wpsd_mac: shared 24x24 multiplier with registered product and a signed
// shift-and-accumulate register; depends on wpsd_pkg
module wpsd_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  wpsd_pkg::wpsd_mac_cmd_type        cmd,
   output logic [wpsd_pkg::PROD_W-1:0]       prod,
   output logic                              acc_neg
);
   import wpsd_pkg::*;

   logic [PROD_W-1:0] prod_ff, prod_in;
   acc_op_type        op_ff, op_in;
   shift_type         shift_ff, shift_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  term;

   // multiply stage
   always_comb begin
      prod_in  = cmd.mul_a * cmd.mul_b;
      op_in    = cmd.acc_op;
      shift_in = cmd.shift;
   end

   // weight the registered product
   always_comb begin
      unique case (shift_ff)
         SHIFT_LOW:  term = ACC_W'(prod_ff);
         SHIFT_MID:  term = ACC_W'(prod_ff) << (MUL_W + 1);
         SHIFT_HIGH: term = ACC_W'(prod_ff) << PROD_W;
         default:    term = '0;
      endcase
   end

   // accumulate stage, two's complement
   always_comb begin
      acc_in = acc_ff;
      if (cmd.clear) begin
         acc_in = '0;
      end else begin
         unique case (op_ff)
            ACC_ADD: acc_in = acc_ff + term;
            ACC_SUB: acc_in = acc_ff - term;
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff  <= ACC_NONE;
         acc_ff <= '0;
      end else begin
         op_ff  <= op_in;
         acc_ff <= acc_in;
      end
      prod_ff  <= prod_in;
      shift_ff <= shift_in;
   end

   assign prod    = prod_ff;
   assign acc_neg = acc_ff[ACC_W-1];

endmodule

// ----- sv/window_position_stability_detector.sv -----
// One sample is in work at a time: req_ready is high only while the sequencer is idle.
// The 21 products go one per cycle through the single 24x24 multiplier in wpsd_mac, plus
// product and difference slots; the verdict waits until the output register is free.
// Reset (synchronous, active high) clears sums, fill count and write slot and loads the
// limit with 104858; the sample ring keeps its contents, the fill count guards reads.
// Depends on wpsd_pkg, wpsd_ram and wpsd_mac.
module window_position_stability_detector (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  wpsd_pkg::wpsd_req_type           req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output wpsd_pkg::wpsd_rsp_type           rsp_data,
   input  logic                             csr_wr_en,
   input  logic [wpsd_pkg::LIMIT_W-1:0]     csr_wr_data
);
   import wpsd_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_OLD,
      ST_SQ_NEW,
      ST_AX_SQ,
      ST_AX_DIFF,
      ST_AX_LOW,
      ST_AX_MID,
      ST_AX_HIGH,
      ST_R_LOW,
      ST_R_MID,
      ST_R_HIGH,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // what to do with the product that comes out next cycle
   typedef enum logic [1:0] {
      USE_NONE,
      USE_S2_SUB,
      USE_S2_ADD,
      USE_DIFF
   } use_type;

   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW);

   state_type              state_ff, state_in;
   axis_type               axis_ff, axis_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [FILL_W-1:0]      fill_ff, fill_in;
   logic signed [S1_W-1:0] s1_ff [AXIS_CNT];
   logic signed [S1_W-1:0] s1_in [AXIS_CNT];
   logic [S2_W-1:0]        s2_ff [AXIS_CNT];
   logic [S2_W-1:0]        s2_in [AXIS_CNT];
   logic [LIMIT_W-1:0]     limit_ff, limit_in;
   wpsd_req_type           sample_ff, sample_in;
   logic                   full_ff, full_in;
   use_type                use_ff, use_in;
   axis_type               use_axis_ff, use_axis_in;
   logic [D_W-1:0]         na_ff, na_in;
   logic [D_W-1:0]         d_ff, d_in;
   logic [R_W-1:0]         r_ff, r_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   wpsd_rsp_type           rsp_data_ff, rsp_data_in;

   logic                   accept;
   logic                   ram_wr_en;
   wpsd_req_type           old_sample;
   wpsd_mac_cmd_type       mac_cmd;
   logic [PROD_W-1:0]      mac_prod;
   logic                   acc_neg;
   logic [DIFF_W-1:0]      na_ext;
   logic [DIFF_W-1:0]      prod_ext;
   logic [MUL_W-1:0]       d_low, d_high, r_low, r_high;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // sample ring, read at transfer, written on the first old-square step
   wpsd_ram #(
      .WIDTH ($bits(wpsd_req_type)),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (slot_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (old_sample)
   );

   wpsd_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mac_cmd),
      .prod    (mac_prod),
      .acc_neg (acc_neg)
   );

   // split operands for the wide squares
   assign d_low    = d_ff[MUL_W-1:0];
   assign d_high   = MUL_W'(d_ff >> MUL_W);
   assign r_low    = r_ff[MUL_W-1:0];
   assign r_high   = MUL_W'(r_ff >> MUL_W);
   assign na_ext   = DIFF_W'(na_ff);
   assign prod_ext = DIFF_W'(mac_prod);

   // sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      limit_in     = limit_ff;
      sample_in    = sample_ff;
      full_in      = full_ff;
      use_in       = USE_NONE;
      use_axis_in  = axis_ff;
      na_in        = na_ff;
      d_in         = d_ff;
      r_in         = r_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      mac_cmd      = '{clear: 1'b0, mul_a: '0, mul_b: '0, acc_op: ACC_NONE, shift: SHIFT_LOW};

      // limit register
      if (csr_wr_en) begin
         limit_in = csr_wr_data;
      end

      // consume the product issued last cycle
      unique case (use_ff)
         USE_S2_SUB: s2_in[use_axis_ff] = s2_ff[use_axis_ff] - S2_W'(mac_prod);
         USE_S2_ADD: s2_in[use_axis_ff] = s2_ff[use_axis_ff] + S2_W'(mac_prod);
         USE_DIFF:   d_in = (na_ext > prod_ext) ? D_W'(na_ext - prod_ext) : '0;
         default:    ;
      endcase

      // result register drains on a transfer
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in     = req_data;
               full_in       = (fill_ff == FILL_FULL);
               r_in          = R_W'(limit_ff) * R_W'(WINDOW * WINDOW);
               mac_cmd.clear = 1'b1;
               axis_in       = AXIS_X;
               state_in      = ST_SQ_OLD;
            end
         end
         ST_SQ_OLD: begin
            // first step: ring write, sums of samples, slot and fill
            if (axis_ff == AXIS_X) begin
               ram_wr_en = 1'b1;
               slot_in   = (slot_ff == SLOT_LAST) ? '0 : SLOT_W'(slot_ff + 1'b1);
               if (fill_ff != FILL_FULL) begin
                  fill_in = FILL_W'(fill_ff + 1'b1);
               end
               for (int k = 0; k < AXIS_CNT; k++) begin
                  s1_in[k] = s1_ff[k] + S1_W'(sample_axis(sample_ff, axis_type'(k)))
                             - (full_ff ? S1_W'(sample_axis(old_sample, axis_type'(k)))
                                        : S1_W'(0));
               end
            end
            mac_cmd.mul_a = MUL_W'(mag_sample(sample_axis(old_sample, axis_ff)));
            mac_cmd.mul_b = MUL_W'(mag_sample(sample_axis(old_sample, axis_ff)));
            use_in        = full_ff ? USE_S2_SUB : USE_NONE;
            if (axis_ff == AXIS_LAST) begin
               axis_in  = AXIS_X;
               state_in = ST_SQ_NEW;
            end else begin
               axis_in = axis_type'(axis_ff + 1'b1);
            end
         end
         ST_SQ_NEW: begin
            mac_cmd.mul_a = MUL_W'(mag_sample(sample_axis(sample_ff, axis_ff)));
            mac_cmd.mul_b = MUL_W'(mag_sample(sample_axis(sample_ff, axis_ff)));
            use_in        = USE_S2_ADD;
            if (axis_ff == AXIS_LAST) begin
               axis_in  = AXIS_X;
               state_in = ST_AX_SQ;
            end else begin
               axis_in = axis_type'(axis_ff + 1'b1);
            end
         end
         ST_AX_SQ: begin
            // square of the sum, and N times the sum of squares
            mac_cmd.mul_a = MUL_W'(mag_sum(s1_ff[axis_ff]));
            mac_cmd.mul_b = MUL_W'(mag_sum(s1_ff[axis_ff]));
            use_in        = USE_DIFF;
            na_in         = D_W'(s2_ff[axis_ff]) * D_W'(WINDOW);
            state_in      = ST_AX_DIFF;
         end
         ST_AX_DIFF: begin
            state_in = ST_AX_LOW;
         end
         ST_AX_LOW: begin
            mac_cmd.mul_a  = d_low;
            mac_cmd.mul_b  = d_low;
            mac_cmd.acc_op = ACC_ADD;
            mac_cmd.shift  = SHIFT_LOW;
            state_in       = ST_AX_MID;
         end
         ST_AX_MID: begin
            mac_cmd.mul_a  = d_high;
            mac_cmd.mul_b  = d_low;
            mac_cmd.acc_op = ACC_ADD;
            mac_cmd.shift  = SHIFT_MID;
            state_in       = ST_AX_HIGH;
         end
         ST_AX_HIGH: begin
            mac_cmd.mul_a  = d_high;
            mac_cmd.mul_b  = d_high;
            mac_cmd.acc_op = ACC_ADD;
            mac_cmd.shift  = SHIFT_HIGH;
            if (axis_ff == AXIS_LAST) begin
               state_in = ST_R_LOW;
            end else begin
               axis_in  = axis_type'(axis_ff + 1'b1);
               state_in = ST_AX_SQ;
            end
         end
         ST_R_LOW: begin
            mac_cmd.mul_a  = r_low;
            mac_cmd.mul_b  = r_low;
            mac_cmd.acc_op = ACC_SUB;
            mac_cmd.shift  = SHIFT_LOW;
            state_in       = ST_R_MID;
         end
         ST_R_MID: begin
            mac_cmd.mul_a  = r_high;
            mac_cmd.mul_b  = r_low;
            mac_cmd.acc_op = ACC_SUB;
            mac_cmd.shift  = SHIFT_MID;
            state_in       = ST_R_HIGH;
         end
         ST_R_HIGH: begin
            mac_cmd.mul_a  = r_high;
            mac_cmd.mul_b  = r_high;
            mac_cmd.acc_op = ACC_SUB;
            mac_cmd.shift  = SHIFT_HIGH;
            state_in       = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // stable when the window is full and the variance norm squared is below the limit squared
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.stable     = (fill_ff == FILL_FULL) && acc_neg;
               rsp_data_in.fill_level = fill_ff;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, sums and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         axis_ff      <= AXIS_X;
         slot_ff      <= '0;
         fill_ff      <= '0;
         limit_ff     <= LIMIT_RESET;
         full_ff      <= 1'b0;
         use_ff       <= USE_NONE;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < AXIS_CNT; k++) begin
            s1_ff[k] <= '0;
            s2_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         limit_ff     <= limit_in;
         full_ff      <= full_in;
         use_ff       <= use_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
      end
      sample_ff   <= sample_in;
      use_axis_ff <= use_axis_in;
      na_ff       <= na_in;
      d_ff        <= d_in;
      r_ff        <= r_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- sv/wpsd_checker.sv -----
// wpsd_checker: port-level assertions for the window position stability detector,
// bound to the top level; depends on wpsd_pkg
module wpsd_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input wpsd_pkg::wpsd_rsp_type rsp_data
);
   import wpsd_pkg::*;

   // one sample at a time: busy right after an input transfer
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted while a sample is in work");

   // fill level never passes the window length
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fill_level <= FILL_W'(WINDOW)))
      else $error("fill level beyond window length");

   // stable only with a full window
   a_stable_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.stable) |-> (rsp_data.fill_level == FILL_W'(WINDOW)))
      else $error("stable reported before window is full");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result changed while stalled");

endmodule

bind window_position_stability_detector wpsd_checker u_wpsd_checker (.*);

// ----- tb/stability_result_checker.sv -----
// stability_result_checker: watches the sample and verdict channels of the
// window position stability detector, predicts each verdict and compares it
// depends on wpsd_pkg for the payload types and window geometry
`timescale 1ns / 100ps

module stability_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  wpsd_pkg::wpsd_req_type       req_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  wpsd_pkg::wpsd_rsp_type       rsp_data,
   input  logic                         csr_wr_en,
   input  logic [wpsd_pkg::LIMIT_W-1:0] csr_wr_data,
   output int                           error_count,
   output int                           pending_count,
   output int                           result_count,
   output int                           stable_count
);
   import wpsd_pkg::*;

   // own copy of the window state
   logic signed [SAMPLE_W-1:0] held [WINDOW][AXIS_CNT];
   logic [SLOT_W-1:0]          next_slot;
   logic [FILL_W-1:0]          held_count;
   logic signed [S1_W-1:0]     axis_sum [AXIS_CNT];
   logic [S2_W-1:0]            axis_sq_sum [AXIS_CNT];
   logic [LIMIT_W-1:0]         limit_reg;

   wpsd_rsp_type predicted_verdicts [$];
   int           fail_total;
   int           checked_total;
   int           stable_total;

   // exact variance norm test: sum of (N*S2 - S1^2)^2 against (limit*N^2)^2
   function automatic logic variance_within_limit();
      logic [127:0]    total;
      logic [127:0]    scaled;
      logic [127:0]    sq_of_sum;
      logic [127:0]    diff;
      logic [127:0]    bound;
      logic [S1_W-1:0] mag;
      int              k;
      total = '0;
      for (k = 0; k < AXIS_CNT; k++) begin
         scaled    = 128'(axis_sq_sum[k]) * 128'(WINDOW);
         mag       = (axis_sum[k] < 0) ? S1_W'(-axis_sum[k]) : S1_W'(axis_sum[k]);
         sq_of_sum = 128'(mag) * 128'(mag);
         diff      = (scaled > sq_of_sum) ? scaled - sq_of_sum : '0;
         total     = total + diff * diff;
      end
      bound = 128'(limit_reg) * 128'(WINDOW * WINDOW);
      return total < bound * bound;
   endfunction

   // push one sample into the window and work out its verdict
   function automatic wpsd_rsp_type push_sample(wpsd_req_type s);
      logic signed [SAMPLE_W-1:0] incoming [AXIS_CNT];
      logic signed [31:0]         sq;
      wpsd_rsp_type               verdict;
      int                         k;
      incoming[AXIS_X] = s.tag_x;
      incoming[AXIS_Y] = s.tag_y;
      incoming[AXIS_Z] = s.tag_z;
      for (k = 0; k < AXIS_CNT; k++) begin
         // full window: retire the oldest sample first
         if (held_count >= WINDOW) begin
            sq             = held[next_slot][k] * held[next_slot][k];
            axis_sum[k]    = axis_sum[k] - held[next_slot][k];
            axis_sq_sum[k] = axis_sq_sum[k] - S2_W'($unsigned(sq));
         end
         sq                 = incoming[k] * incoming[k];
         axis_sum[k]        = axis_sum[k] + incoming[k];
         axis_sq_sum[k]     = axis_sq_sum[k] + S2_W'($unsigned(sq));
         held[next_slot][k] = incoming[k];
      end
      next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
      if (held_count < WINDOW)
         held_count = held_count + 1'b1;
      verdict.fill_level = held_count;
      verdict.stable     = (held_count >= WINDOW) ? variance_within_limit() : 1'b0;
      return verdict;
   endfunction

   // sample both channels and the register port at each edge
   always @(posedge clock) begin
      wpsd_rsp_type want;
      int           k;
      if (reset) begin
         next_slot  = '0;
         held_count = '0;
         limit_reg  = LIMIT_RESET;
         for (k = 0; k < AXIS_CNT; k++) begin
            axis_sum[k]    = '0;
            axis_sq_sum[k] = '0;
         end
         predicted_verdicts.delete();
      end else begin
         if (csr_wr_en)
            limit_reg = csr_wr_data;

         // verdict transfer: compare with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            checked_total++;
            if (rsp_data.stable)
               stable_total++;
            if (predicted_verdicts.size() == 0) begin
               fail_total++;
               $display("%0t: verdict with none predicted, actual stable %0d fill %0d",
                        $time, rsp_data.stable, rsp_data.fill_level);
            end else begin
               want = predicted_verdicts[0];
               predicted_verdicts.delete(0);
               if (rsp_data.stable !== want.stable) begin
                  fail_total++;
                  $display("%0t: stable mismatch, expected %0d, actual %0d",
                           $time, want.stable, rsp_data.stable);
               end
               if (rsp_data.fill_level !== want.fill_level) begin
                  fail_total++;
                  $display("%0t: fill_level mismatch, expected %0d, actual %0d",
                           $time, want.fill_level, rsp_data.fill_level);
               end
            end
         end

         // sample transfer: predict its verdict
         if (req_valid && req_ready)
            predicted_verdicts = {predicted_verdicts, push_sample(req_data)};
      end
      error_count   <= fail_total;
      pending_count <= predicted_verdicts.size();
      result_count  <= checked_total;
      stable_count  <= stable_total;
   end

endmodule

// ----- tb/testbench.sv -----
// testbench: drives position samples and limit writes into the window position
// stability detector with random idling on both channels and gives the verdict
// depends on wpsd_pkg, the detector RTL and stability_result_checker
`timescale 1ns / 100ps

module testbench;
   import wpsd_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int TARGET_SAMPLES = 550;
   localparam int MAX_GAP        = 14;
   localparam int DRAIN_CYCLES   = 40;
   localparam int SETTLE_CYCLES  = 4;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

   typedef enum int {
      MODE_CONST,
      MODE_TIGHT,
      MODE_SPREAD,
      MODE_FULL,
      MODE_RAIL
   } sample_mode_type;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_valid   = 1'b0;
   wpsd_req_type       req_data    = '0;
   logic               rsp_ready   = 1'b0;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;
   logic               req_ready;
   logic               rsp_valid;
   wpsd_rsp_type       rsp_data;

   int error_count;
   int pending_count;
   int result_count;
   int stable_count;
   int cycle_count    = 0;
   int samples_sent   = 0;
   int limit_settings = 0;
   bit quiet_stretch  = 1'b0;

   window_position_stability_detector u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   stability_result_checker u_verdict_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .result_count  (result_count),
      .stable_count  (stable_count)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // idle cycles before one transfer, none inside a quiet stretch
   function automatic int draw_gap();
      return quiet_stretch ? 0 : int'($urandom_range(0, MAX_GAP));
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] near_value(int center, int spread);
      int v;
      v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767)
         v = 32767;
      if (v < -32768)
         v = -32768;
      return SAMPLE_W'(v);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] rail_value();
      return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
   endfunction

   function automatic wpsd_req_type make_sample(sample_mode_type mode, int cx, int cy,
                                                int cz, int spread);
      wpsd_req_type s;
      case (mode)
         MODE_FULL: begin
            s.tag_x = SAMPLE_W'($urandom);
            s.tag_y = SAMPLE_W'($urandom);
            s.tag_z = SAMPLE_W'($urandom);
         end
         MODE_RAIL: begin
            s.tag_x = rail_value();
            s.tag_y = rail_value();
            s.tag_z = rail_value();
         end
         default: begin
            s.tag_x = near_value(cx, spread);
            s.tag_y = near_value(cy, spread);
            s.tag_z = near_value(cz, spread);
         end
      endcase
      return s;
   endfunction

   // one sample transfer; valid stays high across back-to-back samples
   task automatic send_sample(input wpsd_req_type s);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do @(posedge clock); while (req_ready !== 1'b1);
      samples_sent++;
   endtask

   task automatic send_xyz(input int x, input int y, input int z);
      wpsd_req_type s;
      s.tag_x = SAMPLE_W'(x);
      s.tag_y = SAMPLE_W'(y);
      s.tag_z = SAMPLE_W'(z);
      send_sample(s);
   endtask

   // wait until every predicted verdict has come back
   task automatic wait_drained();
      do @(posedge clock); while (pending_count != 0);
   endtask

   // limit write while the detector is idle, no sample offered meanwhile
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      limit_settings++;
   endtask

   function automatic logic [LIMIT_W-1:0] random_limit();
      logic [LIMIT_W-1:0] v;
      case ($urandom_range(0, 4))
         0:       v = LIMIT_W'($urandom_range(0, 1000));
         1:       v = LIMIT_W'($urandom_range(50000, 200000));
         2:       v = LIMIT_W'($urandom);
         3:       v = LIMIT_RESET;
         default: v = LIMIT_W'($urandom_range(1000000, 16777215));
      endcase
      return v;
   endfunction

   function automatic sample_mode_type pick_mode();
      sample_mode_type m;
      case ($urandom_range(0, 9))
         0, 1:    m = MODE_CONST;
         2, 3, 4: m = MODE_TIGHT;
         5, 6, 7: m = MODE_SPREAD;
         8:       m = MODE_FULL;
         default: m = MODE_RAIL;
      endcase
      return m;
   endfunction

   // a run of samples in one mode around one random center, with the odd outlier outside constant runs
   task automatic run_segment(input sample_mode_type mode, input int length);
      int           cx;
      int           cy;
      int           cz;
      int           spread;
      int           i;
      wpsd_req_type s;
      cx = int'($urandom_range(0, 65535)) - 32768;
      cy = int'($urandom_range(0, 65535)) - 32768;
      cz = int'($urandom_range(0, 65535)) - 32768;
      case (mode)
         MODE_TIGHT:  spread = int'($urandom_range(1, 64));
         MODE_SPREAD: spread = int'($urandom_range(64, 128)) << $urandom_range(0, 6);
         default:     spread = 0;
      endcase
      quiet_stretch = ($urandom_range(0, 3) == 0);
      for (i = 0; i < length; i++) begin
         if (mode != MODE_CONST && $urandom_range(0, 19) == 0)
            s = make_sample(MODE_FULL, cx, cy, cz, spread);
         else
            s = make_sample(mode, cx, cy, cz, spread);
         send_sample(s);
      end
   endtask

   // verdict side: random stall before each verdict transfer
   initial begin : verdict_side
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // stimulus
   initial begin : stimulus
      logic [LIMIT_W-1:0] lim;
      int                 phase;
      int                 goal;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and bit patterns while the window fills
      send_xyz(0, 0, 0);
      send_xyz(32767, 32767, 32767);
      send_xyz(-32768, -32768, -32768);
      send_xyz(32767, -32768, 0);
      send_xyz(-32768, 0, 32767);
      send_xyz(0, 32767, -32768);
      send_xyz(-1, -1, -1);
      send_xyz(1, 1, 1);
      send_xyz(-1, 1, -1);
      send_xyz(21845, -21846, 21845);
      send_xyz(-21846, 21845, -21846);
      send_xyz(256, -256, 1024);
      send_xyz(4096, -4096, -1);
      send_xyz(32767, 32767, -32768);

      // limit from reset, window full
      run_segment(MODE_CONST, WINDOW);
      run_segment(MODE_TIGHT, 20);
      run_segment(MODE_SPREAD, 30);

      // limit phases: zero, one, all ones, reset value, then random
      phase = 0;
      while (samples_sent < TARGET_SAMPLES) begin
         case (phase)
            0:       lim = '0;
            1:       lim = LIMIT_W'(1);
            2:       lim = LIMIT_MAX;
            3:       lim = LIMIT_RESET;
            default: lim = random_limit();
         endcase
         write_limit(lim);
         goal = samples_sent + int'($urandom_range(40, 80));
         if (phase < 4)
            run_segment(MODE_CONST, WINDOW + 5);
         while (samples_sent < goal)
            run_segment(pick_mode(), int'($urandom_range(10, 40)));
         phase++;
      end

      req_valid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d samples under %0d limit settings", samples_sent,
               limit_settings + 1);
      $display("%0d verdicts checked, %0d of them stable", result_count, stable_count);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- window_position_stability_detector.f -----
sv/wpsd_pkg.sv
sv/wpsd_ram.sv
sv/wpsd_mac.sv
sv/window_position_stability_detector.sv
sv/wpsd_checker.sv
tb/stability_result_checker.sv
tb/testbench.sv
